>>> hw/rtl/gsoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsoc_pkg
// Shared types and constants of the gyro stillness offset calibrator.
// ----------------------------------------------------------------------------
package gsoc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDER   = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_HOLD      = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] DIVIDER_RST   = 16'd10;
    localparam logic [17:0] THRESHOLD_RST = 18'd15;
    localparam logic [15:0] HOLD_RST      = 16'd2000;

    // Gyro triple, x in the lowest bits.
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_gyro3;

    // One result item, gyro x in the lowest bits.
    typedef struct packed {
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
        logic signed [15:0] gz;
        logic signed [15:0] gy;
        logic signed [15:0] gx;
    } t_sample;

endpackage

>>> hw/rtl/gsoc_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsoc_ring_mem
// Ring store of still gyro samples: one write port and one registered read
// port. A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module gsoc_ring_mem
    import gsoc_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_gyro3        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_gyro3        o_rd_data
);

    t_gyro3 r_mem [DEPTH];
    t_gyro3 r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/gsoc_cal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsoc_cal_core
// Offset subtraction, divided-rate stillness detection and ring bookkeeping.
// ----------------------------------------------------------------------------
module gsoc_cal_core
    import gsoc_pkg::*;
#(
    parameter int RING_DEPTH = 128,
    parameter int IDX_W      = 7,
    parameter int FILL_W     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_acc,
    input  t_gyro3                i_gyro,
    input  logic [31:0]           i_now,
    output logic                  o_res_valid,
    output t_gyro3                o_res_gyro,
    output logic                  o_wr_en,
    output logic [IDX_W-1:0]      o_wr_addr,
    output t_gyro3                o_wr_data,
    output logic [IDX_W-1:0]      o_rd_addr,
    input  t_gyro3                i_rd_data,
    output logic                  o_calibrated
);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(RING_DEPTH);

    function automatic logic [16:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? (17'd0 - d) : d;
    endfunction

    logic [15:0]       r_div;
    logic [17:0]       r_thresh;
    logic [15:0]       r_hold;
    logic              r_cal,   n_cal;
    t_gyro3            r_off,   n_off;
    t_gyro3            r_prev,  n_prev;
    logic [31:0]       r_last,  n_last;
    logic [31:0]       r_start, n_start;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic [FILL_W-1:0] r_fill,  n_fill;

    logic [31:0] w_since_step;
    logic [31:0] w_start_eff;
    logic [31:0] w_since_still;
    logic [17:0] w_turb;
    logic        w_step;
    logic        w_still;
    logic        w_capture;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= DIVIDER_RST;
            r_thresh <= THRESHOLD_RST;
            r_hold   <= HOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIVIDER:   r_div    <= i_cfg_data[15:0];
                CFG_THRESHOLD: r_thresh <= i_cfg_data;
                CFG_HOLD:      r_hold   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_since_step = i_now - r_last;
    assign w_step       = i_acc && (w_since_step >= {16'd0, r_div});
    assign w_turb       = 18'(abs_diff(i_gyro.x, r_prev.x))
                        + 18'(abs_diff(i_gyro.y, r_prev.y))
                        + 18'(abs_diff(i_gyro.z, r_prev.z));
    // A zero start time means unset; it takes the current time on this step.
    assign w_start_eff   = (r_start == 32'd0) ? i_now : r_start;
    assign w_since_still = i_now - w_start_eff;
    assign w_still       = w_turb < r_thresh;
    assign w_capture     = w_step && w_still && (w_since_still > {16'd0, r_hold});

    always_comb begin
        n_cal   = r_cal;
        n_off   = r_off;
        n_prev  = r_prev;
        n_last  = r_last;
        n_start = r_start;
        n_idx   = r_idx;
        n_fill  = r_fill;
        o_wr_en = 1'b0;
        if (w_step) begin
            n_last  = i_now;
            n_prev  = i_gyro;
            n_start = w_still ? w_start_eff : i_now;
        end
        if (w_capture) begin
            if (!r_cal) begin
                n_cal = 1'b1;
                n_off = i_gyro;
            end else begin
                o_wr_en = 1'b1;
                n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                if (r_fill != FULL_FILL) begin
                    n_fill = r_fill + 1'b1;
                end else begin
                    // Prefetched entry after the write slot is the oldest one.
                    n_off = i_rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal   <= 1'b0;
            r_off   <= '0;
            r_prev  <= '0;
            r_last  <= '0;
            r_start <= '0;
            r_idx   <= '0;
            r_fill  <= '0;
        end else begin
            r_cal   <= n_cal;
            r_off   <= n_off;
            r_prev  <= n_prev;
            r_last  <= n_last;
            r_start <= n_start;
            r_idx   <= n_idx;
            r_fill  <= n_fill;
        end
    end

    // The read always looks one slot ahead of the next write position.
    assign o_rd_addr = (n_idx == LAST_IDX) ? '0 : n_idx + 1'b1;
    assign o_wr_addr = r_idx;
    assign o_wr_data = i_gyro;

    assign o_res_valid  = i_acc && r_cal;
    assign o_res_gyro.x = i_gyro.x - r_off.x;
    assign o_res_gyro.y = i_gyro.y - r_off.y;
    assign o_res_gyro.z = i_gyro.z - r_off.z;
    assign o_calibrated = r_cal;

endmodule

>>> hw/rtl/gsoc_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsoc_out_buf
// Output register with a skid stage, so a stalled result does not stop the
// input side until a second result is waiting.
// ----------------------------------------------------------------------------
module gsoc_out_buf
    import gsoc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sample i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_sample o_data,
    input  logic    i_ready
);

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_sample r_out,        n_out;
    t_sample r_skid,       n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_valid;
            end
        end else if (i_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/gyro_still_offset_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_still_offset_calibrator
// Gyro zero-rate offset removal with offset capture on detected stillness.
// ----------------------------------------------------------------------------
// Results are registered in the output buffer. Throughput: one sample per
// cycle while input ready is high; the ring store is read one slot ahead of
// its write pointer, so its registered read never holds up a sample.
// Input ready falls only while the output stalls with a second result held.
// Reset clears all control state and the registers to their defaults; the
// ring contents stay undefined and are only read once every slot is written.
module gyro_still_offset_calibrator
    import gsoc_pkg::*;
#(
    parameter int RING_DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample requests.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // gyro_x_in, gyro_y_in, gyro_z_in, accel_x_in, accel_y_in, accel_z_in,
    // now_ms (from bit 0 up)
    input  logic [127:0]          i_s_tdata,
    // Corrected samples.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // gyro_x_out, gyro_y_out, gyro_z_out, accel_x_out, accel_y_out,
    // accel_z_out (from bit 0 up)
    output logic [95:0]           o_m_tdata,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    logic             w_acc;
    t_gyro3           w_gyro;
    logic             w_res_valid;
    t_gyro3           w_res_gyro;
    t_sample          w_res;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_gyro3           w_wr_data;
    logic [IDX_W-1:0] w_rd_addr;
    t_gyro3           w_rd_data;
    logic             w_calibrated;
    t_sample          w_out;

    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_gyro      = i_s_tdata[47:0];
    assign o_cfg_ready = 1'b1;

    gsoc_cal_core #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W),
        .FILL_W     (FILL_W)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_acc        (w_acc),
        .i_gyro       (w_gyro),
        .i_now        (i_s_tdata[127:96]),
        .o_res_valid  (w_res_valid),
        .o_res_gyro   (w_res_gyro),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .o_calibrated (w_calibrated)
    );

    gsoc_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (IDX_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_res.gx = w_res_gyro.x;
    assign w_res.gy = w_res_gyro.y;
    assign w_res.gz = w_res_gyro.z;
    assign w_res.ax = i_s_tdata[63:48];
    assign w_res.ay = i_s_tdata[79:64];
    assign w_res.az = i_s_tdata[95:80];

    gsoc_out_buf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = w_out;

`ifndef SYNTH
    // A held skid entry implies the output register is also full.
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("skid entry held while output register empty");

    a_ring_write_calibrated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> w_calibrated)
        else $error("ring written before first offset capture");

    a_result_calibrated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_calibrated)
        else $error("result produced while uncalibrated");

    a_calibrated_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_calibrated |=> w_calibrated)
        else $error("calibrated flag dropped without reset");
`endif

endmodule

>>> test/gsoc_offset_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsoc_offset_checker
// Watches the sample, result and configuration channels of the gyro stillness
// offset calibrator. It keeps its own copy of the offset and stillness state,
// predicts each corrected sample and compares it field by field with the
// block's output.
// ----------------------------------------------------------------------------
module gsoc_offset_checker
    import gsoc_pkg::*;
#(
    parameter int RING_DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [127:0]          i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [95:0]           i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_samples,
    output int                    o_results,
    output int                    o_captures,
    output int                    o_ring_takes
);

    logic [15:0] divider;
    logic [17:0] threshold;
    logic [15:0] hold;

    bit          calibrated;
    t_gyro3      offset;
    t_gyro3      prev;
    logic [31:0] last_step;
    logic [31:0] still_start;
    t_gyro3      still_ring [RING_DEPTH];
    int          ring_wr;
    int          ring_count;

    t_sample     corrected_due [$];

    function automatic logic [17:0] axis_step(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d[17:0];
    endfunction

    // Returns whether the sample produces a corrected result, then advances
    // the stillness tracking when the divider lets a step through.
    function automatic bit correct_and_calibrate(input logic [127:0] req,
                                                 output t_sample res);
        t_gyro3      cur;
        logic [31:0] now;
        logic [31:0] elapsed;
        logic [31:0] still_for;
        logic [17:0] turb;
        int          w;
        bit          emitted;
        cur = req[47:0];
        now = req[127:96];
        emitted = calibrated;
        res.gx = cur.x - offset.x;
        res.gy = cur.y - offset.y;
        res.gz = cur.z - offset.z;
        res.ax = req[63:48];
        res.ay = req[79:64];
        res.az = req[95:80];

        elapsed = now - last_step;
        if (elapsed < {16'd0, divider}) return emitted;
        last_step = now;
        turb = axis_step(cur.x, prev.x) + axis_step(cur.y, prev.y)
             + axis_step(cur.z, prev.z);
        prev = cur;
        if (still_start == 32'd0) still_start = now;

        if (turb < threshold) begin
            still_for = now - still_start;
            if (still_for > {16'd0, hold}) begin
                if (!calibrated) begin
                    calibrated = 1'b1;
                    offset = cur;
                    o_captures++;
                end else begin
                    w = ring_wr;
                    still_ring[w] = cur;
                    w = w + 1;
                    if (w >= RING_DEPTH) w = 0;
                    ring_wr = w;
                    // The step that completes the fill leaves the offset alone.
                    if (ring_count < RING_DEPTH) begin
                        ring_count++;
                    end else begin
                        offset = still_ring[w];
                        o_ring_takes++;
                    end
                end
            end
        end else begin
            still_start = now;
        end
        return emitted;
    endfunction

    function automatic string field_label(input int f);
        case (f)
            0: return "gyro_x_out";
            1: return "gyro_y_out";
            2: return "gyro_z_out";
            3: return "accel_x_out";
            4: return "accel_y_out";
            default: return "accel_z_out";
        endcase
    endfunction

    task automatic flag_error(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        logic [95:0] want;
        t_sample     res;
        if (!i_rst_n) begin
            divider     = DIVIDER_RST;
            threshold   = THRESHOLD_RST;
            hold        = HOLD_RST;
            calibrated  = 1'b0;
            offset      = '0;
            prev        = '0;
            last_step   = '0;
            still_start = '0;
            ring_wr     = 0;
            ring_count  = 0;
            corrected_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DIVIDER:   divider = i_cfg_data[15:0];
                    CFG_THRESHOLD: threshold = i_cfg_data;
                    CFG_HOLD:      hold = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Results leave from the registered output buffer, never at their request's
            // own edge, so they are matched before this edge's request is predicted.
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (corrected_due.size() == 0) begin
                    flag_error($sformatf("result %h arrived with nothing expected",
                                         i_m_tdata));
                end else begin
                    want = corrected_due.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (i_m_tdata[16*f +: 16] !== want[16*f +: 16])
                            flag_error($sformatf("%s expected %h got %h",
                                                 field_label(f), want[16*f +: 16],
                                                 i_m_tdata[16*f +: 16]));
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                o_samples++;
                if (correct_and_calibrate(i_s_tdata, res)) corrected_due.push_back(res);
            end
        end
        o_outstanding = corrected_due.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the gyro stillness offset calibrator: a directed opening over
// field extremes, divider skips, wrapping timestamps and offset capture, then
// random still stretches mixed with noise under several register settings,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import gsoc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [127:0]          i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [95:0]           o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatches;
    int outstanding;
    int samples;
    int results;
    int captures;
    int ring_takes;

    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    bit          sink_hold_req = 1'b0;
    logic [31:0] stamp = 32'd3000;
    t_gyro3      base = '0;

    gyro_still_offset_calibrator #(.RING_DEPTH(128)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    gsoc_offset_checker #(.RING_DEPTH(128)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding),
        .o_samples    (samples),
        .o_results    (results),
        .o_captures   (captures),
        .o_ring_takes (ring_takes)
    );

    always #4 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests never toggle it.
    task automatic push_sample(input logic [127:0] req);
        int  gap;
        bit  done;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = req;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = o_s_tready;
            @(negedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [15:0] gx, input logic [15:0] gy,
                               input logic [15:0] gz, input logic [15:0] ax,
                               input logic [15:0] ay, input logic [15:0] az,
                               input logic [31:0] now);
        push_sample({now, az, ay, ax, gz, gy, gx});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle();
        i_s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_phase(input logic [15:0] div, input logic [17:0] thr,
                             input logic [15:0] hld);
        settle();
        write_reg(CFG_DIVIDER, {2'b00, div});
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_HOLD, {2'b00, hld});
    endtask

    // Mostly still stretches around a slowly changing base with small jitter
    // and advancing time; the rest is fully random noise, timestamps included.
    task automatic run_random(input int n, input int max_dt, input int jitter,
                              input int noise_pct);
        logic [127:0] req;
        logic [15:0]  gx, gy, gz;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                req = {$urandom, $urandom, $urandom, $urandom};
            end else begin
                if ($urandom_range(0, 39) == 0) base = 48'({$urandom, $urandom});
                stamp = stamp + $urandom_range(0, max_dt);
                gx = base.x + 16'($urandom_range(0, jitter)) - 16'(jitter / 2);
                gy = base.y + 16'($urandom_range(0, jitter)) - 16'(jitter / 2);
                gz = base.z + 16'($urandom_range(0, jitter)) - 16'(jitter / 2);
                req = {stamp, 16'($urandom), 16'($urandom), 16'($urandom), gz, gy, gx};
            end
            push_sample(req);
        end
    endtask

    // Result side: random stalls per result, plus one long hold-off on request.
    initial begin : sink
        int stall;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                i_m_tready = 1'b0;
                repeat (200) @(negedge i_clk);
            end
            stall = sink_gaps ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: divider 10, threshold 15, hold 2000.
        send_fields(16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 32'd0);
        send_fields(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                    -16'sd1, 32'd10);
        send_fields(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd1, 16'sd2, 16'sd3, 32'd15);
        send_fields(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd4, 16'sd5, 16'sd6, 32'd20);
        send_fields(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd7, 16'sd8, 16'sd9, 32'd30);
        // Still for just over the hold time: the offset is captured here.
        send_fields(-16'sd32767, 16'sd32767, -16'sd32768, 16'sd10, 16'sd11, 16'sd12,
                    32'd2021);
        // Correction wraps at 16 bits.
        send_fields(16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd32767,
                    -16'sd32768, 32'd2025);
        // Timestamp jumps to the top of its range, then wraps to zero.
        send_fields(16'sd100, -16'sd100, 16'sd5, -16'sd1, 16'sd0, 16'sd1, 32'hFFFF_FFFF);
        send_fields(16'sd100, -16'sd100, 16'sd5, 16'sd2, 16'sd3, 16'sd4, 32'd0);
        send_fields(16'sd100, -16'sd100, 16'sd5, 16'sd5, 16'sd6, 16'sd7, 32'd20);
        // A turbulent step at time zero leaves the still start unset.
        send_fields(-16'sd5000, 16'sd7000, 16'sd123, 16'sd8, 16'sd9, 16'sd10, 32'd0);
        send_fields(-16'sd5000, 16'sd7000, 16'sd123, 16'sd11, 16'sd12, 16'sd13, 32'd30);
        send_fields(-16'sd5000, 16'sd7001, 16'sd124, 16'sd14, 16'sd15, 16'sd16, 32'd2031);
        send_fields(-16'sd4990, 16'sd7001, 16'sd124, 16'sd17, 16'sd18, 16'sd19, 32'd2041);

        // Every sample steps, nothing counts as still.
        set_phase(16'd0, 18'd0, 16'd0);
        write_reg(CFG_SPARE, '1);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        run_random(100, 3, 2000, 20);

        // Everything is still: the ring fills and wraps several times.
        set_phase(16'd1, 18'd262143, 16'd0);
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        sink_hold_req = 1'b1;
        run_random(500, 3, 50, 10);

        set_phase(16'd5, 18'd40, 16'd30);
        run_random(350, 10, 8, 10);

        set_phase(16'd65535, 18'd1000, 16'd65535);
        src_gaps = 1'b0;
        run_random(200, 70000, 100, 10);

        set_phase(DIVIDER_RST, THRESHOLD_RST, HOLD_RST);
        src_gaps = 1'b1;
        run_random(300, 30, 4, 10);

        settle();
        $display("Run covered %0d sample requests and %0d corrected results", samples,
                 results);
        $display("under five register settings; %0d stillness captures, %0d ring offsets.",
                 captures, ring_takes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("gyro_still_offset_calibrator: match");
        end else begin
            $display("gyro_still_offset_calibrator: mismatch");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d results still expected.", outstanding);
        $display("gyro_still_offset_calibrator: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/gsoc_pkg.sv
hw/rtl/gsoc_ring_mem.sv
hw/rtl/gsoc_cal_core.sv
hw/rtl/gsoc_out_buf.sv
hw/rtl/gyro_still_offset_calibrator.sv
test/gsoc_offset_checker.sv
test/tb.sv
